// File: hw/rtl/ncn_pkg.sv
// ncn_pkg: shared types, codes and constants of the neighbor cache engine
`default_nettype none
package ncn_pkg;
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int TIMER_BITS_DEF = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_LEARN = 2'd1;
  localparam logic [1:0] OP_CONFIRM = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_TX = 3'd1;
  localparam logic [2:0] ACT_DROP = 3'd2;
  localparam logic [2:0] ACT_MSOL = 3'd3;
  localparam logic [2:0] ACT_USOL = 3'd4;

  localparam logic [1:0] STS_OK = 2'd0;
  localparam logic [1:0] STS_UNREACH = 2'd1;
  localparam logic [1:0] STS_FULL = 2'd2;

  localparam logic [2:0] NS_INCOMPLETE = 3'd0;
  localparam logic [2:0] NS_REACHABLE = 3'd1;
  localparam logic [2:0] NS_STALE = 3'd2;
  localparam logic [2:0] NS_DELAY = 3'd3;
  localparam logic [2:0] NS_PROBE = 3'd4;
  localparam logic [2:0] NS_FAILED = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_IPV6_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REACHABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRANS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_PROBE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MCAST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_UCAST = 3'd5;

  localparam logic [15:0] REACHABLE_RST = 16'd30000;
  localparam logic [15:0] RETRANS_RST = 16'd1000;
  localparam logic [15:0] DELAY_PROBE_RST = 16'd5000;
  localparam logic [3:0] MAX_SOLICIT_RST = 4'd3;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] status;
    logic [15:0] out_handle;
    logic [47:0] out_l2_addr;
    logic [63:0] out_l3_hi;
    logic [63:0] out_l3_lo;
    logic last;
  } ncn_res_t;
endpackage
`default_nettype wire

// File: hw/rtl/ncn_if.sv
// ncn_in_if / ncn_out_if: valid-ready channels for request and result items
`default_nettype none
interface ncn_in_if;
  logic valid;
  logic ready;
  logic [1:0] opcode;
  logic [63:0] l3_addr_hi;
  logic [63:0] l3_addr_lo;
  logic [47:0] l2_addr;
  logic solicited;
  logic [15:0] packet_handle;
  modport source (output valid, opcode, l3_addr_hi, l3_addr_lo, l2_addr, solicited,
                  packet_handle, input ready);
  modport sink (input valid, opcode, l3_addr_hi, l3_addr_lo, l2_addr, solicited,
                packet_handle, output ready);
endinterface

interface ncn_out_if;
  logic valid;
  logic ready;
  logic [2:0] action;
  logic [1:0] status;
  logic [15:0] out_handle;
  logic [47:0] out_l2_addr;
  logic [63:0] out_l3_hi;
  logic [63:0] out_l3_lo;
  logic last;
  modport source (output valid, action, status, out_handle, out_l2_addr, out_l3_hi,
                  out_l3_lo, last, input ready);
  modport sink (input valid, action, status, out_handle, out_l2_addr, out_l3_hi,
                out_l3_lo, last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/neighbor_cache_nud_engine.sv
// neighbor_cache_nud_engine: neighbor cache with reachability detection
`default_nettype none
// One item at a time. A scan reads each table entry in turn from the entry
// memory (read, then evaluate) and stalls while the result channel is full;
// then send, learn and confirm act on the matched or free entry.
// Results of one item leave in order, the final one flagged by last;
// one result is held back so that last can be set on it.
module neighbor_cache_nud_engine #(
  parameter int TABLE_DEPTH = ncn_pkg::TABLE_DEPTH_DEF,
  parameter int TIMER_BITS = ncn_pkg::TIMER_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  ncn_in_if.sink in_ch,
  ncn_out_if.source out_ch,
  input wire logic cfg_we,
  input wire logic [ncn_pkg::CFG_IDX_W-1:0] cfg_idx,
  input wire logic [ncn_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ncn_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(MAX_RESULTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
  localparam logic [31:0] TMAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

  typedef struct packed {
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [47:0] link;
    logic [2:0] st;
    logic [3:0] probe;
    logic [TIMER_BITS-1:0] timer;
    logic [15:0] ph;
  } entry_t;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD = 3'd1;
  localparam logic [2:0] S_EV = 3'd2;
  localparam logic [2:0] S_ARD = 3'd3;
  localparam logic [2:0] S_ACT = 3'd4;
  localparam logic [2:0] S_FIN = 3'd5;

  function automatic logic [TIMER_BITS-1:0] sat_load(input logic [15:0] t);
    logic [31:0] wide;
    wide = {16'd0, t};
    if (wide > TMAX) begin
      return TMAX[TIMER_BITS-1:0];
    end
    return wide[TIMER_BITS-1:0];
  endfunction

  logic ipv6_r;
  logic [15:0] reach_r, retrans_r, dprobe_r;
  logic [3:0] mmax_r, umax_r;

  logic [2:0] state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [1:0] op_r;
  logic [63:0] hi_r, lo_r;
  logic [47:0] l2_r;
  logic sol_r;
  logic [15:0] h_r;
  logic match_r, free_r;
  logic [IW-1:0] mi_r, fi_r;
  logic [CW-1:0] cnt_r;

  logic [TABLE_DEPTH-1:0] valid_r, armed_r, pend_r;
  entry_t mem [TABLE_DEPTH];
  entry_t rd_r;

  logic hold_v_r, out_v_r;
  ncn_res_t hold_r, out_r;
  ncn_res_t hold_fin;

  entry_t w;
  logic wr;
  logic [IW-1:0] waddr;
  logic set_valid, armed_we, armed_val, pend_we, pend_val;
  logic res_go;
  ncn_res_t res;
  logic out_free, stall, key_hit, gives, accept;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free = !out_v_r || out_ch.ready;
  assign stall = res_go && hold_v_r && !out_free;
  assign key_hit = ipv6_r ? (rd_r.key_hi == hi_r && rd_r.key_lo == lo_r)
                          : (rd_r.key_lo[31:0] == lo_r[31:0]);

  assign out_ch.valid = out_v_r;
  assign out_ch.action = out_r.action;
  assign out_ch.status = out_r.status;
  assign out_ch.out_handle = out_r.out_handle;
  assign out_ch.out_l2_addr = out_r.out_l2_addr;
  assign out_ch.out_l3_hi = out_r.out_l3_hi;
  assign out_ch.out_l3_lo = out_r.out_l3_lo;
  assign out_ch.last = out_r.last;

  always_comb begin
    hold_fin = hold_r;
    hold_fin.last = 1'b1;
  end

  always_comb begin
    w = rd_r;
    wr = 1'b0;
    waddr = idx_r;
    set_valid = 1'b0;
    armed_we = 1'b0;
    armed_val = 1'b0;
    pend_we = 1'b0;
    pend_val = 1'b0;
    res_go = 1'b0;
    res = '0;
    gives = 1'b0;
    case (rd_r.st)
      NS_DELAY: gives = ipv6_r;
      NS_PROBE: gives = (rd_r.probe >= umax_r) ? pend_r[idx_r] : ipv6_r;
      NS_INCOMPLETE: gives = (rd_r.probe >= mmax_r) ? pend_r[idx_r] : 1'b1;
      default: gives = 1'b0;
    endcase
    case (state_r)
      S_EV: begin
        if (op_r == OP_TICK && valid_r[idx_r] && armed_r[idx_r]) begin
          wr = 1'b1;
          if (rd_r.timer > TIMER_BITS'(1)) begin
            w.timer = rd_r.timer - TIMER_BITS'(1);
          end else if (cnt_r >= CW'(MAX_RESULTS) && gives) begin
            w.timer = TIMER_BITS'(1);
          end else begin
            armed_we = 1'b1;
            case (rd_r.st)
              NS_REACHABLE: w.st = NS_STALE;
              NS_DELAY, NS_PROBE: begin
                if (rd_r.st == NS_PROBE && rd_r.probe >= umax_r) begin
                  w.st = NS_FAILED;
                  if (pend_r[idx_r]) begin
                    pend_we = 1'b1;
                    res_go = 1'b1;
                    res.action = ACT_DROP;
                    res.status = STS_UNREACH;
                    res.out_handle = rd_r.ph;
                  end
                end else begin
                  w.st = NS_PROBE;
                  w.probe = (rd_r.st == NS_DELAY) ? 4'd1 : rd_r.probe + 4'd1;
                  armed_val = 1'b1;
                  w.timer = sat_load(retrans_r);
                  if (ipv6_r) begin
                    res_go = 1'b1;
                    res.action = ACT_USOL;
                    res.out_l2_addr = rd_r.link;
                    res.out_l3_hi = rd_r.key_hi;
                    res.out_l3_lo = rd_r.key_lo;
                  end
                end
              end
              NS_INCOMPLETE: begin
                if (rd_r.probe >= mmax_r) begin
                  w.st = NS_FAILED;
                  if (pend_r[idx_r]) begin
                    pend_we = 1'b1;
                    res_go = 1'b1;
                    res.action = ACT_DROP;
                    res.status = STS_UNREACH;
                    res.out_handle = rd_r.ph;
                  end
                end else begin
                  w.probe = rd_r.probe + 4'd1;
                  armed_val = 1'b1;
                  w.timer = sat_load(retrans_r);
                  res_go = 1'b1;
                  res.action = ACT_MSOL;
                  res.out_l3_hi = rd_r.key_hi;
                  res.out_l3_lo = rd_r.key_lo;
                end
              end
              default: w.st = rd_r.st;
            endcase
          end
        end
      end
      S_ACT: begin
        waddr = match_r ? mi_r : fi_r;
        if (!match_r) begin
          w.key_hi = ipv6_r ? hi_r : 64'd0;
          w.key_lo = ipv6_r ? lo_r : {32'd0, lo_r[31:0]};
          w.link = '0;
          w.probe = '0;
          w.timer = '0;
          w.ph = '0;
        end
        case (op_r)
          OP_SEND: begin
            res_go = 1'b1;
            if (match_r) begin
              case (rd_r.st)
                NS_STALE: begin
                  wr = 1'b1;
                  w.st = NS_DELAY;
                  armed_we = 1'b1;
                  armed_val = 1'b1;
                  w.timer = sat_load(dprobe_r);
                  res.action = ACT_TX;
                  res.out_handle = h_r;
                  res.out_l2_addr = rd_r.link;
                end
                NS_INCOMPLETE: begin
                  wr = 1'b1;
                  pend_we = 1'b1;
                  pend_val = 1'b1;
                  w.ph = h_r;
                  if (pend_r[mi_r]) begin
                    res.action = ACT_DROP;
                    res.out_handle = rd_r.ph;
                  end
                end
                NS_FAILED: begin
                  res.action = ACT_DROP;
                  res.status = STS_UNREACH;
                  res.out_handle = h_r;
                end
                default: begin
                  res.action = ACT_TX;
                  res.out_handle = h_r;
                  res.out_l2_addr = rd_r.link;
                end
              endcase
            end else if (free_r) begin
              wr = 1'b1;
              set_valid = 1'b1;
              w.st = NS_INCOMPLETE;
              w.probe = 4'd1;
              pend_we = 1'b1;
              pend_val = 1'b1;
              w.ph = h_r;
              armed_we = 1'b1;
              armed_val = 1'b1;
              w.timer = sat_load(retrans_r);
              res.action = ACT_MSOL;
              res.out_l3_hi = w.key_hi;
              res.out_l3_lo = w.key_lo;
            end else begin
              res.action = ACT_DROP;
              res.status = STS_FULL;
              res.out_handle = h_r;
            end
          end
          OP_LEARN: begin
            if (match_r || free_r) begin
              wr = 1'b1;
              set_valid = !match_r;
              if (!match_r) begin
                pend_we = 1'b1;
              end
              w.link = l2_r;
              w.probe = '0;
              armed_we = 1'b1;
              if (sol_r) begin
                w.st = NS_REACHABLE;
                armed_val = 1'b1;
                w.timer = sat_load(reach_r);
                if (match_r && pend_r[mi_r]) begin
                  pend_we = 1'b1;
                  res_go = 1'b1;
                  res.action = ACT_TX;
                  res.out_handle = rd_r.ph;
                  res.out_l2_addr = l2_r;
                end
              end else begin
                w.st = NS_STALE;
              end
            end
          end
          OP_CONFIRM: begin
            if (match_r && rd_r.st != NS_INCOMPLETE && rd_r.st != NS_FAILED) begin
              wr = 1'b1;
              w.st = NS_REACHABLE;
              w.probe = '0;
              armed_we = 1'b1;
              armed_val = 1'b1;
              w.timer = sat_load(reach_r);
            end
          end
          default: wr = 1'b0;
        endcase
      end
      default: wr = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RD;
          idx_nxt = '0;
        end
      end
      S_RD: state_nxt = S_EV;
      S_EV: begin
        if (!stall) begin
          if (idx_r != LAST_IDX) begin
            idx_nxt = idx_r + IW'(1);
            state_nxt = S_RD;
          end else if (op_r == OP_TICK) begin
            state_nxt = S_FIN;
          end else if (match_r || (valid_r[idx_r] && key_hit)) begin
            idx_nxt = match_r ? mi_r : idx_r;
            state_nxt = S_ARD;
          end else begin
            state_nxt = S_ACT;
          end
        end
      end
      S_ARD: state_nxt = S_ACT;
      S_ACT: begin
        if (!stall) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!hold_v_r || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[idx_r];
    if (wr && !stall) begin
      mem[waddr] <= w;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_ch.opcode;
      hi_r <= in_ch.l3_addr_hi;
      lo_r <= in_ch.l3_addr_lo;
      l2_r <= in_ch.l2_addr;
      sol_r <= in_ch.solicited;
      h_r <= in_ch.packet_handle;
    end
    if (state_r == S_EV) begin
      if (valid_r[idx_r] && key_hit && !match_r) begin
        mi_r <= idx_r;
      end
      if (!valid_r[idx_r] && !free_r) begin
        fi_r <= idx_r;
      end
    end
    if (res_go && !stall) begin
      hold_r <= res;
      if (hold_v_r) begin
        out_r <= hold_r;
      end
    end else if (state_r == S_FIN && hold_v_r && out_free) begin
      out_r <= hold_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
      match_r <= 1'b0;
      free_r <= 1'b0;
      cnt_r <= '0;
      valid_r <= '0;
      armed_r <= '0;
      pend_r <= '0;
      hold_v_r <= 1'b0;
      out_v_r <= 1'b0;
      ipv6_r <= 1'b0;
      reach_r <= REACHABLE_RST;
      retrans_r <= RETRANS_RST;
      dprobe_r <= DELAY_PROBE_RST;
      mmax_r <= MAX_SOLICIT_RST;
      umax_r <= MAX_SOLICIT_RST;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_IPV6_MODE: ipv6_r <= cfg_wdata[0];
          CFG_REACHABLE: reach_r <= cfg_wdata;
          CFG_RETRANS: retrans_r <= cfg_wdata;
          CFG_DELAY_PROBE: dprobe_r <= cfg_wdata;
          CFG_MAX_MCAST: mmax_r <= cfg_wdata[3:0];
          CFG_MAX_UCAST: umax_r <= cfg_wdata[3:0];
          default: ipv6_r <= ipv6_r;
        endcase
      end
      if (accept) begin
        match_r <= 1'b0;
        free_r <= 1'b0;
        cnt_r <= '0;
      end
      if (state_r == S_EV) begin
        if (valid_r[idx_r] && key_hit) begin
          match_r <= 1'b1;
        end
        if (!valid_r[idx_r]) begin
          free_r <= 1'b1;
        end
      end
      if (!stall) begin
        if (set_valid) begin
          valid_r[waddr] <= 1'b1;
        end
        if (armed_we) begin
          armed_r[waddr] <= armed_val;
        end
        if (pend_we) begin
          pend_r[waddr] <= pend_val;
        end
      end
      if (res_go && !stall) begin
        hold_v_r <= 1'b1;
        cnt_r <= cnt_r + CW'(1);
      end else if (state_r == S_FIN && hold_v_r && out_free) begin
        hold_v_r <= 1'b0;
      end
      if ((res_go && !stall && hold_v_r) ||
          (state_r == S_FIN && hold_v_r && out_free)) begin
        out_v_r <= 1'b1;
      end else if (out_v_r && out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !hold_v_r)
    else $error("held result left over in idle");
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_RESULTS))
    else $error("result count over limit");
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_RD && idx_r == '0))
    else $error("scan did not start at entry zero");
  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable(idx_r))
    else $error("scan moved while result path was blocked");
endmodule
`default_nettype wire
